>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Character codes, the blank cell, action codes, field widths, the sequencer
// state type and the flags that the cursor step hands to the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // field widths of the request and response transactions
   localparam int COL_FIELD_W  = 7;
   localparam int ROW_FIELD_W  = 5;
   localparam int CODE_W       = 8;
   localparam int COLOR_W      = 4;
   localparam int CELL_W       = 16;

   // action codes
   localparam logic ACTION_PUT  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // character codes with special handling
   localparam logic [CODE_W-1:0] CODE_NONE      = 8'h00;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;

   // blank cell: white on black, space
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   // sequencer states
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } tcw_state_type;

   // control flags produced by the cursor step
   typedef struct packed {
      logic cell_write;
      logic overflow;
   } tcw_step_flags_type;

endpackage

>>> design/tcw_cursor_step.sv
// ----------------------------------------------------------------------------
// tcw_cursor_step: cursor update for one put transaction
// Works out the next cursor, the cell to write with its value, and whether
// the cursor ran past the last row so that the store must be blanked.
// ----------------------------------------------------------------------------
module tcw_cursor_step #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                     put_en,
   input  logic [tcw_pkg::CODE_W-1:0]               char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]              back_color,
   input  logic [tcw_pkg::COLOR_W-1:0]              fore_color,
   input  logic [$clog2(COLUMNS)-1:0]               cur_col,
   input  logic [$clog2(ROWS)-1:0]                  cur_row,
   output logic [$clog2(COLUMNS)-1:0]               next_col,
   output logic [$clog2(ROWS)-1:0]                  next_row,
   output logic [$clog2(COLUMNS*ROWS)-1:0]          wr_addr,
   output logic [tcw_pkg::CELL_W-1:0]               wr_data,
   output tcw_pkg::tcw_step_flags_type              flags
);
   import tcw_pkg::*;

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);
   localparam int AW = $clog2(COLUMNS * ROWS);

   logic          last_col;
   logic          last_row;
   logic [CW-1:0] wr_col;

   assign last_col = (cur_col == CW'(COLUMNS - 1));
   assign last_row = (cur_row == RW'(ROWS - 1));

   // decode the character and advance the cursor
   always_comb begin
      next_col = cur_col;
      next_row = cur_row;
      wr_col   = cur_col;
      wr_data  = {back_color, fore_color, char_code};
      flags    = '0;
      if (put_en && (char_code != CODE_NONE)) begin
         case (char_code)
            CODE_NEWLINE: begin
               next_col = '0;
               if (last_row) begin
                  flags.overflow = 1'b1;
               end else begin
                  next_row = cur_row + RW'(1);
               end
            end
            CODE_BACKSPACE: begin
               if (cur_col != '0) begin
                  next_col = cur_col - CW'(1);
               end
               wr_col           = next_col;
               wr_data          = BLANK_CELL;
               flags.cell_write = 1'b1;
            end
            default: begin
               flags.cell_write = 1'b1;
               if (last_col) begin
                  next_col = '0;
                  if (last_row) begin
                     flags.overflow = 1'b1;
                  end else begin
                     next_row = cur_row + RW'(1);
                  end
               end else begin
                  next_col = cur_col + CW'(1);
               end
            end
         endcase
         // home the cursor after running past the last row
         if (flags.overflow) begin
            next_col = '0;
            next_row = '0;
         end
      end
   end

   // cell address in row-major order
   assign wr_addr = AW'(cur_row) * AW'(COLUMNS) + AW'(wr_col);

endmodule

>>> design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core: text console with a cell store and a cursor
// Holds COLUMNS x ROWS 16-bit cells in one synchronous RAM and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): action 0 puts char_code with its colors at the
//   cursor; action 1 reads the cell at read_col/read_row. Each request gives
//   exactly one response transaction (rsp_*) with the cursor after the
//   request, the cell read (zero for a put) and a screen-cleared flag.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while the response side keeps up and no
//   sweep runs.
//   Clearing: after reset, and after any put that runs past the last row,
//   the store is swept to blank, one cell a cycle, all COLUMNS*ROWS cells
//   (2000 at the default size). req_stall stays high during the sweep; the
//   response of the overflowing put is delivered right away.
//   Stall: while rsp_stall holds a pending response, req_stall is raised and
//   the response and the cursor are held; a running sweep goes on.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [tcw_pkg::CODE_W-1:0]          req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]         req_back_color,
   input  logic [tcw_pkg::COLOR_W-1:0]         req_fore_color,
   input  logic [tcw_pkg::COL_FIELD_W-1:0]     req_read_col,
   input  logic [tcw_pkg::ROW_FIELD_W-1:0]     req_read_row,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tcw_pkg::COL_FIELD_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::ROW_FIELD_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::CELL_W-1:0]          rsp_cell_value,
   output logic                                rsp_screen_cleared
);
   import tcw_pkg::*;

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int DEPTH = COLUMNS * ROWS;
   localparam int AW    = $clog2(DEPTH);

   // cell store
   logic [CELL_W-1:0] mem [DEPTH];
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              mem_re;
   logic [AW-1:0]     mem_ra;
   logic [CELL_W-1:0] rd_data_ff;

   // control state
   tcw_state_type     state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COL_FIELD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_FIELD_W-1:0] rsp_row_ff, rsp_row_in;
   logic                   rsp_cleared_ff, rsp_cleared_in;
   logic                   rsp_cell_sel_ff, rsp_cell_sel_in;

   // cursor step outputs
   logic                   accept;
   logic                   is_put;
   logic                   read_in_range;
   logic [CW-1:0]          step_col;
   logic [RW-1:0]          step_row;
   logic [AW-1:0]          step_addr;
   logic [CELL_W-1:0]      step_data;
   tcw_step_flags_type     step_flags;

   assign req_stall = (state_ff != ST_RUN) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_put    = accept && (req_action == ACTION_PUT);

   assign read_in_range = ({1'b0, req_read_col} < 8'(COLUMNS)) &&
                          ({2'b0, req_read_row} < 7'(ROWS));

   tcw_cursor_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_step (
      .put_en     (is_put),
      .char_code  (req_char_code),
      .back_color (req_back_color),
      .fore_color (req_fore_color),
      .cur_col    (cur_col_ff),
      .cur_row    (cur_row_ff),
      .next_col   (step_col),
      .next_row   (step_row),
      .wr_addr    (step_addr),
      .wr_data    (step_data),
      .flags      (step_flags)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // next state, RAM port control, cursor and response
   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      mem_we          = 1'b0;
      mem_wa          = step_addr;
      mem_wd          = step_data;
      mem_re          = 1'b0;
      mem_ra          = AW'(req_read_row) * AW'(COLUMNS) + AW'(req_read_col);
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_cleared_in  = rsp_cleared_ff;
      rsp_cell_sel_in = rsp_cell_sel_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // sweep blank cells through the store
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = BLANK_CELL;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in    = ST_RUN;
               clr_addr_in = '0;
            end
         end
         ST_RUN: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (req_action == ACTION_READ) begin
                  mem_re          = read_in_range;
                  rsp_cell_sel_in = read_in_range;
                  rsp_cleared_in  = 1'b0;
               end else begin
                  mem_we          = step_flags.cell_write;
                  cur_col_in      = step_col;
                  cur_row_in      = step_row;
                  rsp_cell_sel_in = 1'b0;
                  rsp_cleared_in  = step_flags.overflow;
                  if (step_flags.overflow) begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                  end
               end
               rsp_col_in = COL_FIELD_W'(cur_col_in);
               rsp_row_in = ROW_FIELD_W'(cur_row_in);
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // cursor and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_cleared_ff  <= rsp_cleared_in;
      rsp_cell_sel_ff <= rsp_cell_sel_in;
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // drive the response channel
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_col     = rsp_col_ff;
   assign rsp_cursor_row     = rsp_row_ff;
   assign rsp_cell_value     = rsp_cell_sel_ff ? rd_data_ff : '0;
   assign rsp_screen_cleared = rsp_cleared_ff;

endmodule
